// ===== rtl/sha1bsh_pkg.sv =====
// shared constants, types and command/status structs of the sha-1 byte stream hasher
`timescale 1ns / 1ps
`default_nettype none
package sha1bsh_pkg;

   localparam int WORD_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int POS_W       = $clog2(BLOCK_BYTES);
   localparam int ROUNDS      = 80;
   localparam int ROUND_W     = $clog2(ROUNDS);
   localparam int CHAIN_WORDS = 5;
   localparam int INDEX_W     = 3;
   localparam int TOTAL_W     = 61;
   localparam int LEN_W       = 64;
   localparam int LEN_POS     = 56;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type PAD_HEAD = 8'h80;

   localparam word_type H_INIT [CHAIN_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_TAB [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   // request type codes
   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // source of the byte written into the block buffer
   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_HEAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         byte_we;
      byte_sel_type byte_sel;
      logic         count_total;
      logic         load_work;
      logic         round_en;
      logic         final_add;
      logic         emit_next;
   } dp_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             round_last;
      logic             word_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/sha1bsh_if.sv =====
// valid/ready channel interfaces for requests and digest words
`timescale 1ns / 1ps
`default_nettype none
interface sha1bsh_req_if;
   import sha1bsh_pkg::*;

   logic     valid;
   logic     ready;
   logic     req_type;
   byte_type data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface sha1bsh_rsp_if;
   import sha1bsh_pkg::*;

   logic               valid;
   logic               ready;
   word_type           digest_word;
   logic [INDEX_W-1:0] word_index;
   logic               last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/sha1bsh_datapath.sv =====
// block buffer, message schedule, round unit, chaining words and counters
`timescale 1ns / 1ps
`default_nettype none
module sha1bsh_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  sha1bsh_pkg::dp_cmd_type      cmd,
   input  sha1bsh_pkg::byte_type        data_byte,
   output sha1bsh_pkg::dp_status_type   status,
   output sha1bsh_pkg::word_type        digest_word,
   output logic [sha1bsh_pkg::INDEX_W-1:0] word_index,
   output logic                         last_word
);
   import sha1bsh_pkg::*;

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   word_type               chain_ff [CHAIN_WORDS];
   word_type               work_ff  [CHAIN_WORDS];
   word_type               sched_ff [BLOCK_WORDS];
   logic [TOTAL_W-1:0]     total_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [ROUND_W-1:0]     round_ff;
   logic [INDEX_W-1:0]     idx_ff;

   logic [LEN_W-1:0]       bit_len;
   byte_type               len_byte;
   byte_type               byte_in;
   logic [1:0]             group;
   word_type               f_val;
   word_type               t_val;
   word_type               w_next;
   logic                   idx_last;

   assign bit_len  = {total_ff, 3'b000};
   // length bytes go out most significant first at positions 56..63
   assign len_byte = bit_len[{~pos_ff[2:0], 3'b000} +: BYTE_W];

   always_comb begin
      unique case (cmd.byte_sel)
         SEL_DATA: byte_in = data_byte;
         SEL_HEAD: byte_in = PAD_HEAD;
         SEL_ZERO: byte_in = '0;
         SEL_LEN:  byte_in = len_byte;
         default:  byte_in = '0;
      endcase
   end

   always_comb begin
      if (round_ff < ROUND_W'(20))      group = 2'd0;
      else if (round_ff < ROUND_W'(40)) group = 2'd1;
      else if (round_ff < ROUND_W'(60)) group = 2'd2;
      else                              group = 2'd3;
   end

   always_comb begin
      unique case (group)
         2'd0:    f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd2:    f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                          | (work_ff[2] & work_ff[3]);
         default: f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign t_val  = rotl(work_ff[0], 5) + f_val + work_ff[4] + K_TAB[group] + sched_ff[0];
   assign w_next = rotl(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0], 1);

   assign idx_last = (idx_ff == INDEX_W'(CHAIN_WORDS - 1));

   // control counters and chaining words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAIN_WORDS; i++) chain_ff[i] <= H_INIT[i];
         total_ff <= '0;
         pos_ff   <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.byte_we)     pos_ff   <= pos_ff + POS_W'(1);
         if (cmd.count_total) total_ff <= total_ff + TOTAL_W'(1);
         if (cmd.load_work)     round_ff <= '0;
         else if (cmd.round_en) round_ff <= round_ff + ROUND_W'(1);
         if (cmd.final_add) begin
            for (int i = 0; i < CHAIN_WORDS; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
         if (cmd.emit_next) begin
            if (idx_last) begin
               idx_ff   <= '0;
               total_ff <= '0;
               for (int i = 0; i < CHAIN_WORDS; i++) chain_ff[i] <= H_INIT[i];
            end else begin
               idx_ff <= idx_ff + INDEX_W'(1);
            end
         end
      end
   end

   // block buffer doubles as the 16-word schedule window
   always_ff @(posedge clock) begin
      if (cmd.byte_we) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            sched_ff[i] <= {sched_ff[i][WORD_W-BYTE_W-1:0], sched_ff[i+1][WORD_W-1 -: BYTE_W]};
         end
         sched_ff[BLOCK_WORDS-1] <= {sched_ff[BLOCK_WORDS-1][WORD_W-BYTE_W-1:0], byte_in};
      end else if (cmd.round_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[BLOCK_WORDS-1] <= w_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_work) begin
         for (int i = 0; i < CHAIN_WORDS; i++) work_ff[i] <= chain_ff[i];
      end else if (cmd.round_en) begin
         work_ff[0] <= t_val;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= rotl(work_ff[1], 30);
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3];
      end
   end

   assign status.pos        = pos_ff;
   assign status.round_last = (round_ff == ROUND_W'(ROUNDS - 1));
   assign status.word_last  = idx_last;

   assign digest_word = chain_ff[idx_ff];
   assign word_index  = idx_ff;
   assign last_word   = idx_last;

endmodule
`default_nettype wire

// ===== rtl/sha1bsh_ctrl.sv =====
// sequencer for byte intake, padding, compression rounds and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha1bsh_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   input  wire                         req_type,
   output logic                        req_ready,
   input  wire                         rsp_ready,
   output logic                        rsp_valid,
   output sha1bsh_pkg::dp_cmd_type     cmd,
   input  sha1bsh_pkg::dp_status_type  status
);
   import sha1bsh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_HEAD,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   state_type resume_ff, resume_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      pos_last;
   logic      pos_pre_len;

   assign pos_last    = (status.pos == POS_W'(BLOCK_BYTES - 1));
   assign pos_pre_len = (status.pos == POS_W'(LEN_POS - 1));

   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      cmd       = '0;
      cmd.byte_sel = SEL_DATA;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               if (req_type == REQ_DATA) begin
                  cmd.byte_we     = 1'b1;
                  cmd.count_total = 1'b1;
                  if (pos_last) begin
                     cmd.load_work = 1'b1;
                     state_in      = ST_ROUND;
                     resume_in     = ST_IDLE;
                  end
               end else begin
                  state_in = ST_PAD_HEAD;
               end
            end
         end
         ST_PAD_HEAD: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = SEL_HEAD;
            if (pos_last) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               resume_in     = ST_PAD_ZERO;
            end else if (pos_pre_len) begin
               state_in = ST_PAD_LEN;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = SEL_ZERO;
            if (pos_last) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               resume_in     = ST_PAD_ZERO;
            end else if (pos_pre_len) begin
               state_in = ST_PAD_LEN;
            end
         end
         ST_PAD_LEN: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (pos_last) begin
               cmd.load_work = 1'b1;
               state_in      = ST_ROUND;
               resume_in     = ST_EMIT;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.final_add = 1'b1;
            state_in      = resume_ff;
         end
         ST_EMIT: begin
            if (rsp_valid_ff && rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.word_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resume_ff    <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_EMIT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> state_ff == ST_IDLE)
      else $error("request ready outside idle");

   a_valid_tracks_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_EMIT))
      else $error("response valid out of step with emit state");

   a_final_after_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |-> $past(state_ff) == ST_ROUND)
      else $error("chaining update without rounds");

   a_compress_on_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load_work |-> pos_last && cmd.byte_we)
      else $error("compression started on a partial block");

endmodule
`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher.sv =====
// top level of the sha-1 byte stream hasher: sequencer plus datapath
`timescale 1ns / 1ps
`default_nettype none
// usage
//  - req_chan carries one transaction per message byte (req_type 0, data_byte)
//    or a finish transaction (req_type 1, data_byte ignored)
//  - rsp_chan returns the 160-bit digest as five 32-bit words, word_index 0..4,
//    last_word set on the fifth; the words come only after a finish
//  - data bytes are taken back to back while idle; the 64th byte of a block
//    also starts the compression: 80 rounds at one round per cycle on a single
//    round unit, then the chaining add, and req_chan.ready stays low until that
//    add is done, so that byte holds off the next one
//  - a finish leads into padding, one padding byte per cycle outside the
//    compressions, up to the end of the length field (64 - pos bytes when pos
//    < 56, else 128 - pos), one compression per filled block, one or two blocks;
//    the first digest word is shown the cycle after the last chaining add
//  - digest words leave one per cycle while rsp_chan.ready is high; a stall
//    holds the current word; the next message can start once the fifth word
//    is taken, with the chaining words reloaded and the length cleared
//  - the block works on one transaction at a time: req_chan.ready is high only
//    while idle
//  - synchronous reset restores the initial chaining values and a zero length;
//    no clearing pass is needed
module sha1_byte_stream_hasher (
   input  wire clock,
   input  wire reset,
   sha1bsh_req_if.sink   req_chan,
   sha1bsh_rsp_if.source rsp_chan
);
   import sha1bsh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: decides which byte goes into the block and when to compress
   sha1bsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: byte buffer, schedule, round unit, chaining words
   sha1bsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_chan.data_byte),
      .status      (status),
      .digest_word (rsp_chan.digest_word),
      .word_index  (rsp_chan.word_index),
      .last_word   (rsp_chan.last_word)
   );

endmodule
`default_nettype wire
